@@ src/lfr_pkg.sv @@
// Shared constants and types for the LED fade ramp controller.
package lfr_pkg;

  localparam int unsigned LEVEL_W       = 8;
  localparam int unsigned RAMP_W        = 16;
  localparam int unsigned PROD_W        = 2 * RAMP_W;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = RAMP_W;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  localparam logic [LEVEL_W-1:0] TARGET_RST = 8'd255;
  localparam logic [RAMP_W-1:0]  RISE_RST   = 16'd1000;
  localparam logic [RAMP_W-1:0]  FALL_RST   = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_RISE   = 3'd1,
    CFG_FALL   = 3'd2,
    CFG_ANODE  = 3'd3
  } lfr_cfg_e;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_REQ  = 1'b1
  } lfr_kind_e;

endpackage

@@ src/lfr_in_if.sv @@
// Input channel: millisecond ticks and on/off requests.
interface lfr_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic turn_on;

  modport source (output valid, output kind, output turn_on, input ready);
  modport sink   (input valid, input kind, input turn_on, output ready);
endinterface

@@ src/lfr_out_if.sv @@
// Output channel: brightness level, PWM duty and ramp status.
interface lfr_out_if import lfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] duty;
  logic               duty_changed;
  logic               ramping;

  modport source (output valid, output level, output duty, output duty_changed,
                  output ramping, input ready);
  modport sink   (input valid, input level, input duty, input duty_changed,
                  input ramping, output ready);
endinterface

@@ src/led_fade_ramp_controller_top.sv @@
// LED fade ramp controller: ramp sequencer, shared multiplier and divider.
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    kind, turn_on
//  out_o    out  valid/ready    level, duty, duty_changed, ramping
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// A tick or request that needs a division passes through accept, evaluate,
// one multiply, divider load, the divider steps, divider done and the result
// load. Other items skip to the result. The bit-serial divider sets the long path.
// Reset gives the register defaults and an idle, dark lamp.
// A result waits in the output register; a new item is taken while it waits,
// but the next result is held back until the waiting one is taken.
module led_fade_ramp_controller_top import lfr_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lfr_in_if.sink                in_i,
  lfr_out_if.source             out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_START = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [LEVEL_W-1:0]   target_q;
  logic [RAMP_W-1:0]    rise_q, fall_q;
  logic                 anode_q;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic                 want_q, want_d;
  logic                 active_q, active_d;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic [LEVEL_W-1:0]   before_q, before_d;
  logic                 kind_q, kind_d;
  logic                 turn_q, turn_d;
  logic [RAMP_W-1:0]    op_a_q, op_a_d;
  logic [RAMP_W-1:0]    op_b_q, op_b_d;
  logic [RAMP_W-1:0]    dvsr_q, dvsr_d;
  logic [PROD_W-1:0]    prod_q;
  logic                 out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]   out_level_q, out_duty_q;
  logic                 out_chg_q, out_ramp_q;

  logic [TIME_BITS-1:0] elapsed;
  logic                 elapsed_big;
  logic [RAMP_W-1:0]    elapsed_lo;
  logic [RAMP_W-1:0]    len, old_len, new_len;
  logic                 div_start, div_done;
  logic [PROD_W-1:0]    div_quo;
  logic                 out_load;

  assign elapsed     = now_q - start_q;
  assign elapsed_big = |elapsed[TIME_BITS-1:RAMP_W];
  assign elapsed_lo  = elapsed[RAMP_W-1:0];
  assign len         = want_q ? rise_q : fall_q;
  assign old_len     = turn_q ? fall_q : rise_q;
  assign new_len     = turn_q ? rise_q : fall_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      rise_q   <= RISE_RST;
      fall_q   <= FALL_RST;
      anode_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET: target_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_RISE:   rise_q   <= cfg_data_i;
        CFG_FALL:   fall_q   <= cfg_data_i;
        CFG_ANODE:  anode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    start_d     = start_q;
    want_d      = want_q;
    active_d    = active_q;
    level_d     = level_q;
    before_d    = before_q;
    kind_d      = kind_q;
    turn_d      = turn_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    dvsr_d      = dvsr_q;
    out_valid_d = out_valid_q;
    div_start   = 1'b0;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d   = in_i.kind;
          turn_d   = in_i.turn_on;
          before_d = level_q;
          if (in_i.kind == KIND_TICK) begin
            now_d = now_q + 1'b1;
          end
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        state_d = S_OUT;
        if (kind_q == KIND_TICK) begin
          if (active_q) begin
            if (elapsed_big || elapsed_lo >= len) begin
              active_d = 1'b0;
              level_d  = want_q ? target_q : '0;
            end else begin
              op_a_d  = {{(RAMP_W-LEVEL_W){1'b0}}, target_q};
              op_b_d  = want_q ? elapsed_lo : (fall_q - elapsed_lo);
              dvsr_d  = len;
              state_d = S_MUL;
            end
          end
        end else if (want_q != turn_q) begin
          want_d = turn_q;
          if (!active_q) begin
            start_d  = now_q;
            active_d = 1'b1;
          end else if (elapsed_big || elapsed_lo > old_len || old_len == '0) begin
            start_d = now_q;
          end else begin
            op_a_d  = new_len;
            op_b_d  = old_len - elapsed_lo;
            dvsr_d  = old_len;
            state_d = S_MUL;
          end
        end
      end
      // The product register fills during this step, so the divider loads in the S_START step that follows.
      S_MUL: begin
        state_d = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (kind_q == KIND_TICK) begin
            level_d = div_quo[LEVEL_W-1:0];
          end else begin
            start_d = now_q - {{(TIME_BITS-RAMP_W){1'b0}}, div_quo[RAMP_W-1:0]};
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      start_q     <= '0;
      want_q      <= 1'b0;
      active_q    <= 1'b0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      start_q     <= start_d;
      want_q      <= want_d;
      active_q    <= active_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    before_q <= before_d;
    kind_q   <= kind_d;
    turn_q   <= turn_d;
    op_a_q   <= op_a_d;
    op_b_q   <= op_b_d;
    dvsr_q   <= dvsr_d;
    prod_q   <= op_a_q * op_b_q;
    if (out_load) begin
      out_level_q <= level_q;
      out_duty_q  <= anode_q ? level_q : (LEVEL_MAX - level_q);
      out_chg_q   <= (level_q != before_q);
      out_ramp_q  <= active_q;
    end
  end

  lfr_div #(
    .DIVIDEND_W(PROD_W),
    .DIVISOR_W (RAMP_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (dvsr_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.level        = out_level_q;
  assign out_o.duty         = out_duty_q;
  assign out_o.duty_changed = out_chg_q;
  assign out_o.ramping      = out_ramp_q;

  // A ramp ends only while a tick is being evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> $past(state_q == S_CALC && kind_q == KIND_TICK))
    else $error("ramp ended outside tick evaluation");

  // Requests never move the brightness.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(level_q) |-> $past(kind_q == KIND_TICK))
    else $error("level changed on a request");

  // The divider only reports back while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  // A new result is loaded only from the result step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result loaded outside the result step");

  // No item is taken while a computation is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_START || state_q == S_DIV) |-> !in_i.ready)
    else $error("input ready during computation");

endmodule

@@ src/lfr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module lfr_div #(
  parameter int unsigned DIVIDEND_W = 32,
  parameter int unsigned DIVISOR_W  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvsr_q, dvsr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  fits;

  assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, dvsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvsr_d = dvsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvsr_d = divisor_i;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dvsr_q}) : rem_sh;
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ tb/led_fade_ramp_controller_top_tb.sv @@
// Self-checking testbench for the LED fade ramp controller top level.
`timescale 1ns / 1ps

module led_fade_ramp_controller_top_tb;
  import lfr_pkg::*;

  localparam int unsigned TIME_W = TIME_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned MAX_PRINTED = 200;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  typedef struct {
    lfr_kind_e kind;
    logic      turn_on;
  } lamp_item_t;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] duty;
    logic               duty_changed;
    logic               ramping;
  } lamp_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lfr_in_if  in_bus ();
  lfr_out_if out_bus ();

  led_fade_ramp_controller_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // Lamp model state and its copy of the registers.
  logic [LEVEL_W-1:0] cfg_target;
  logic [RAMP_W-1:0]  cfg_rise;
  logic [RAMP_W-1:0]  cfg_fall;
  logic               cfg_anode;
  logic [TIME_W-1:0]  clk_ms;
  logic [TIME_W-1:0]  ramp_t0;
  logic               lamp_wish;
  logic               fading;
  logic [LEVEL_W-1:0] bright;

  lamp_item_t   pending_items[$];
  lamp_result_t expected_levels[$];
  int unsigned  items_queued;
  int unsigned  results_checked;
  int unsigned  mismatch_count;
  int unsigned  send_gap_pct;
  int unsigned  recv_stall_pct;
  logic         plan_wish;
  logic         in_fire;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string field, int got, int want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
    end
  endtask

  // Advances the lamp model by one item and returns what the block should report.
  function automatic lamp_result_t predict_lamp(lamp_item_t it);
    logic [TIME_W-1:0]  elapsed;
    logic [LEVEL_W-1:0] prior;
    logic [63:0]        old_len;
    logic [63:0]        new_len;
    logic [63:0]        num;
    logic [63:0]        quot;
    lamp_result_t       res;
    prior = bright;
    if (it.kind == KIND_TICK) begin
      clk_ms = clk_ms + 1'b1;
      if (fading) begin
        elapsed = clk_ms - ramp_t0;
        if (lamp_wish) begin
          if (elapsed >= cfg_rise) begin
            fading = 1'b0;
            bright = cfg_target;
          end else begin
            num = cfg_target;
            quot = (num * elapsed) / cfg_rise;
            bright = quot[LEVEL_W-1:0];
          end
        end else begin
          if (elapsed >= cfg_fall) begin
            fading = 1'b0;
            bright = '0;
          end else begin
            num = cfg_target;
            quot = (num * (cfg_fall - elapsed)) / cfg_fall;
            bright = quot[LEVEL_W-1:0];
          end
        end
      end
    end else if (it.turn_on != lamp_wish) begin
      lamp_wish = it.turn_on;
      if (!fading) begin
        ramp_t0 = clk_ms;
        fading = 1'b1;
      end else begin
        elapsed = clk_ms - ramp_t0;
        old_len = it.turn_on ? cfg_fall : cfg_rise;
        new_len = it.turn_on ? cfg_rise : cfg_fall;
        if (elapsed > old_len || old_len == 0) begin
          ramp_t0 = clk_ms;
        end else begin
          // Back-date the start so the brightness carries on from where it is.
          quot = ((old_len - elapsed) * new_len) / old_len;
          ramp_t0 = clk_ms - quot[TIME_W-1:0];
        end
      end
    end
    res.level = bright;
    res.duty = cfg_anode ? bright : LEVEL_MAX - bright;
    res.duty_changed = (bright != prior);
    res.ramping = fading;
    return res;
  endfunction

  // Monitor: checks results first, then predicts the item taken at this edge.
  always @(posedge clk_i) begin : monitor_b
    lamp_item_t   got_item;
    lamp_result_t want;
    in_fire <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_levels.pop_front();
          if (out_bus.level !== want.level) begin
            report_mismatch("level", out_bus.level, want.level);
          end
          if (out_bus.duty !== want.duty) begin
            report_mismatch("duty", out_bus.duty, want.duty);
          end
          if (out_bus.duty_changed !== want.duty_changed) begin
            report_mismatch("duty_changed", out_bus.duty_changed, want.duty_changed);
          end
          if (out_bus.ramping !== want.ramping) begin
            report_mismatch("ramping", out_bus.ramping, want.ramping);
          end
          results_checked++;
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        got_item.kind = lfr_kind_e'(in_bus.kind);
        got_item.turn_on = in_bus.turn_on;
        expected_levels.push_back(predict_lamp(got_item));
      end
    end
  end

  // Driver: presents the next item once the current one is taken.
  always @(negedge clk_i) begin : driver_b
    lamp_item_t nxt;
    if (rst_ni) begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_bus.valid || in_fire) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pending_items.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.kind <= nxt.kind;
          in_bus.turn_on <= nxt.turn_on;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_item(lfr_kind_e kind, logic turn_on);
    lamp_item_t it;
    it.kind = kind;
    it.turn_on = turn_on;
    pending_items.push_back(it);
    items_queued++;
    if (kind == KIND_REQ) begin
      plan_wish = turn_on;
    end
  endtask

  task automatic push_ticks(int unsigned n);
    repeat (n) push_item(KIND_TICK, 1'($urandom_range(1)));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_TARGET: cfg_target = data[LEVEL_W-1:0];
      CFG_RISE:   cfg_rise = data;
      CFG_FALL:   cfg_fall = data;
      CFG_ANODE:  cfg_anode = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [LEVEL_W-1:0] target, logic [RAMP_W-1:0] rise,
                          logic [RAMP_W-1:0] fall, logic anode);
    write_reg(CFG_TARGET, CFG_DATA_W'(target));
    write_reg(CFG_RISE, rise);
    write_reg(CFG_FALL, fall);
    write_reg(CFG_ANODE, CFG_DATA_W'(anode));
  endtask

  function automatic logic [RAMP_W-1:0] pick_ramp_len();
    if ($urandom_range(9) == 0) begin
      return RAMP_W'($urandom_range(31, 65535));
    end
    return RAMP_W'($urandom_range(1, 30));
  endfunction

  task automatic pick_regs(int unsigned mode);
    logic [LEVEL_W-1:0] target;
    case (mode)
      1: set_regs(8'd255, 16'd65535, 16'd1, 1'b1);
      4: set_regs(8'd0, 16'd1, 16'd65535, 1'b0);
      7: set_regs(8'd255, 16'd1, 16'd1, 1'b0);
      default: begin
        case ($urandom_range(3))
          0: target = '0;
          1: target = LEVEL_MAX;
          default: target = LEVEL_W'($urandom_range(255));
        endcase
        set_regs(target, pick_ramp_len(), pick_ramp_len(), 1'($urandom_range(1)));
      end
    endcase
  endtask

  // Mostly ticks; most on/off requests reverse the lamp so ramps get turned around.
  task automatic push_random(int unsigned n);
    logic on;
    repeat (n) begin
      if ($urandom_range(99) < 20) begin
        on = ($urandom_range(3) != 0) ? !plan_wish : 1'($urandom_range(1));
        push_item(KIND_REQ, on);
      end else begin
        push_item(KIND_TICK, 1'($urandom_range(1)));
      end
    end
  endtask

  // Waits until every result is back and the block has had time to go quiet.
  task automatic wait_drained();
    while (results_checked != items_queued) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TARGET;
    cfg_data_i = '0;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_TICK;
    in_bus.turn_on = 1'b0;
    out_bus.ready = 1'b0;
    in_fire = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    items_queued = 0;
    results_checked = 0;
    mismatch_count = 0;
    plan_wish = 1'b0;
    cfg_target = TARGET_RST;
    cfg_rise = RISE_RST;
    cfg_fall = FALL_RST;
    cfg_anode = 1'b1;
    clk_ms = '0;
    ramp_t0 = '0;
    lamp_wish = 1'b0;
    fading = 1'b0;
    bright = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Short ramps with inverted duty: idle tick, redundant request, start from idle,
    // reversals in both directions, and ramps running to their end.
    set_regs(8'd255, 16'd6, 16'd4, 1'b0);
    write_reg(CFG_SPARE, 16'hFFFF);
    push_item(KIND_TICK, 1'b1);
    push_item(KIND_REQ, 1'b0);
    push_item(KIND_REQ, 1'b1);
    push_ticks(2);
    push_item(KIND_REQ, 1'b0);
    push_ticks(1);
    push_item(KIND_REQ, 1'b1);
    push_ticks(5);
    push_item(KIND_REQ, 1'b1);
    push_item(KIND_REQ, 1'b0);
    push_ticks(4);
    wait_drained();

    // Shortest ramps end on their first tick.
    set_regs(8'd128, 16'd1, 16'd1, 1'b1);
    push_item(KIND_REQ, 1'b1);
    push_ticks(1);
    push_item(KIND_REQ, 1'b0);
    push_ticks(1);
    wait_drained();

    // Leave a rise running, shorten it, then reverse after it would have ended.
    set_regs(8'd200, 16'd50, 16'd50, 1'b1);
    push_item(KIND_REQ, 1'b1);
    push_ticks(3);
    wait_drained();
    write_reg(CFG_RISE, 16'd2);
    push_item(KIND_REQ, 1'b0);
    push_ticks(2);
    wait_drained();

    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 58; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 58; end
        default: begin send_gap_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int unsigned seg = 0; seg < 3; seg++) begin
        pick_regs(phase * 3 + seg);
        push_random(42);
        wait_drained();
      end
    end

    if (expected_levels.size() != 0) begin
      report_mismatch("missing results", 0, expected_levels.size());
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
